// File: design/dmx_usb_packet_formatter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the DMX USB packet formatter
// Each check samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DMX_USB_PACKET_FORMATTER_UNIT_ASSERT_SVH
`define DMX_USB_PACKET_FORMATTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication: cons must hold whenever ante holds.
`define DMXUSB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmxusb: implication check failed");
// Next-cycle implication: cons must hold in the cycle after ante.
`define DMXUSB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmxusb: next-cycle check failed");
`else
`define DMXUSB_ASSERT_IMP(lbl, ante, cons)
`define DMXUSB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: design/dmxusb_pkg.sv
// ----------------------------------------------------------------------------
// dmxusb_pkg
// Shared constants, types and frame layout helper for the formatter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmxusb_pkg;

  localparam int unsigned CHUNKS_PER_FRAME = 26;
  localparam int unsigned CHUNK_BYTES      = 32;
  localparam int unsigned CHANS_PER_CHUNK  = 20;
  localparam int unsigned DMX_CHANNELS     = 512;
  localparam int unsigned FRAME_BYTES      = CHUNKS_PER_FRAME * CHUNK_BYTES;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned ADDR_W = 9;
  localparam int unsigned CHNK_W = 5;

  localparam logic [CHNK_W-1:0] LAST_CHUNK = CHNK_W'(CHUNKS_PER_FRAME - 1);
  localparam logic [IDX_W-1:0]  FRAME_END  = IDX_W'(FRAME_BYTES);

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Status codes
  localparam logic STS_OK    = 1'b0;
  localparam logic STS_RANGE = 1'b1;

  // Frame byte constants
  localparam logic [7:0] BYTE_MARK     = 8'h80;
  localparam logic [7:0] BYTE_TAG_MORE = 8'h84;
  localparam logic [7:0] BYTE_TAG_LAST = 8'h04;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;

  typedef enum logic [2:0] {
    SLOT_MARK,
    SLOT_IDX,
    SLOT_TAG,
    SLOT_LEVEL,
    SLOT_ZERO
  } slot_kind_t;

  typedef struct packed {
    slot_kind_t  kind;
    logic [2:0]  grp;
    logic [1:0]  lane;
  } slot_t;

  // Decoded request handed from the decoder to the pipeline
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic              use_mem;
    logic [7:0]        const_byte;
    logic              status;
  } dec_t;

  // Classify a byte offset inside a chunk: marker, group index, tag, level or pad.
  function automatic slot_t dmxusb_slot(input logic [CHNK_W-1:0] off);
    slot_t            s;
    logic [CHNK_W-1:0] om1;
    logic [CHNK_W-1:0] pos;
    begin
      s.kind = SLOT_ZERO;
      s.grp  = 3'd0;
      s.lane = 2'd0;
      om1    = off - CHNK_W'(1);
      if (om1 >= CHNK_W'(24)) begin
        s.grp = 3'd4;
      end else if (om1 >= CHNK_W'(18)) begin
        s.grp = 3'd3;
      end else if (om1 >= CHNK_W'(12)) begin
        s.grp = 3'd2;
      end else if (om1 >= CHNK_W'(6)) begin
        s.grp = 3'd1;
      end
      pos = om1 - CHNK_W'(s.grp) * CHNK_W'(6);
      if (off == CHNK_W'(0)) begin
        s.kind = SLOT_MARK;
      end else if (off == CHNK_W'(CHUNK_BYTES - 1)) begin
        s.kind = SLOT_ZERO;
      end else if (pos == CHNK_W'(0)) begin
        s.kind = SLOT_IDX;
      end else if (pos == CHNK_W'(1)) begin
        s.kind = SLOT_TAG;
      end else begin
        s.kind = SLOT_LEVEL;
        s.lane = pos[1:0] - 2'd2;
      end
      return s;
    end
  endfunction

endpackage

// File: design/dmxusb_decode.sv
// ----------------------------------------------------------------------------
// dmxusb_decode
// Decode one registered request into store access and constant frame byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmxusb_decode
  import dmxusb_pkg::*;
(
  input  logic             cmd,
  input  logic [IDX_W-1:0] index,
  output dec_t             dec
);

  logic [CHNK_W-1:0] chunk;
  logic [CHNK_W-1:0] off;
  logic              last;
  slot_t             slot;
  logic [IDX_W-1:0]  chan;
  logic [IDX_W-1:0]  half_idx;
  logic              pad_grp;
  logic              in_frame;

  assign chunk    = index[IDX_W-1 -: CHNK_W];
  assign off      = index[CHNK_W-1:0];
  assign last     = (chunk == LAST_CHUNK);
  assign slot     = dmxusb_slot(off);
  assign chan     = IDX_W'(chunk) * IDX_W'(CHANS_PER_CHUNK)
                  + IDX_W'({slot.grp, 2'b00}) + IDX_W'(slot.lane);
  assign half_idx = IDX_W'(chunk) * IDX_W'(10) + IDX_W'({slot.grp, 1'b0});
  // The short last chunk carries three groups only; its marker still stands
  assign pad_grp  = last && (slot.grp >= 3'd3) && (slot.kind != SLOT_MARK);
  assign in_frame = (index < FRAME_END);

  always_comb begin
    dec.wr_en      = 1'b0;
    dec.addr       = chan[ADDR_W-1:0];
    dec.use_mem    = 1'b0;
    dec.const_byte = BYTE_ZERO;
    dec.status     = STS_OK;
    if (cmd == CMD_WRITE) begin
      dec.addr   = index[ADDR_W-1:0];
      dec.wr_en  = !index[ADDR_W];
      dec.status = index[ADDR_W] ? STS_RANGE : STS_OK;
    end else if (!in_frame) begin
      dec.status = STS_RANGE;
    end else if (!pad_grp) begin
      unique case (slot.kind)
        SLOT_MARK:  dec.const_byte = BYTE_MARK;
        SLOT_IDX:   dec.const_byte = half_idx[7:0];
        SLOT_TAG: begin
          dec.const_byte = ((slot.grp == 3'd4) || (last && slot.grp == 3'd2))
                         ? BYTE_TAG_LAST : BYTE_TAG_MORE;
        end
        SLOT_LEVEL: dec.use_mem = !chan[ADDR_W];
        default:    dec.const_byte = BYTE_ZERO;
      endcase
    end
  end

endmodule

// File: design/dmxusb_store.sv
// ----------------------------------------------------------------------------
// dmxusb_store
// Channel level memory with registered read and a clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmxusb_store
  import dmxusb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data,
  output logic              clr_done
);

  logic [7:0]      mem [DMX_CHANNELS];
  logic [ADDR_W:0] clr_cnt_r;
  logic [ADDR_W:0] clr_cnt_nxt;
  logic [7:0]      rd_data_r;

  // Top bit set once every entry has been zeroed
  assign clr_done    = clr_cnt_r[ADDR_W];
  assign clr_cnt_nxt = clr_done ? clr_cnt_r : clr_cnt_r + (ADDR_W+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!clr_done) begin
      mem[clr_cnt_r[ADDR_W-1:0]] <= BYTE_ZERO;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/dmx_usb_packet_formatter_unit.sv
// ----------------------------------------------------------------------------
// dmx_usb_packet_formatter_unit
// DMX channel store that serves bytes of the 832-byte USB frame on request.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   in_       input      in_valid/in_ready    in_cmd, in_index, in_level
//   out_      output     out_valid/out_ready  out_frame_byte, out_status
//
// One request is taken per cycle while the result register is not stalled;
// its result is offered through three registers (input register, store read
// register, result register).
// The store's single read port and registered read call for the read register.
// After reset a clearing pass zeroes the 512 levels, one per cycle; in_ready
// stays low until the pass ends.
// A stalled result (out_valid high, out_ready low) freezes every stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "dmx_usb_packet_formatter_unit_assert.svh"

module dmx_usb_packet_formatter_unit
  import dmxusb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_cmd,
  input  logic [IDX_W-1:0] in_index,
  input  logic [7:0]       in_level,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_frame_byte,
  output logic             out_status
);

  // Stage valids
  logic             s1_vld_r, s1_vld_nxt;
  logic             s2_vld_r, s2_vld_nxt;
  logic             out_vld_r, out_vld_nxt;

  // Stage payloads
  logic             s1_cmd_r;
  logic [IDX_W-1:0] s1_index_r;
  logic [7:0]       s1_level_r;
  logic             s2_use_mem_r;
  logic [7:0]       s2_const_r;
  logic             s2_status_r;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_status_r;

  logic             adv;
  logic             accept;
  logic             clr_done;
  logic [7:0]       rd_data;
  dec_t             dec;

  // Advance all stages together unless the result register is stalled
  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv && clr_done;
  assign accept   = in_valid && in_ready;

  assign s1_vld_nxt  = adv ? accept   : s1_vld_r;
  assign s2_vld_nxt  = adv ? s1_vld_r : s2_vld_r;
  assign out_vld_nxt = adv ? s2_vld_r : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s2_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r   <= in_cmd;
      s1_index_r <= in_index;
      s1_level_r <= in_level;
    end
  end

  // Decode the held request: store address, write strobe, constant byte
  dmxusb_decode u_decode (
    .cmd   (s1_cmd_r),
    .index (s1_index_r),
    .dec   (dec)
  );

  // Write the level and read the channel for this request in the same stage
  dmxusb_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (adv && s1_vld_r && dec.wr_en),
    .wr_addr  (dec.addr),
    .wr_data  (s1_level_r),
    .rd_en    (adv),
    .rd_addr  (dec.addr),
    .rd_data  (rd_data),
    .clr_done (clr_done)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_use_mem_r <= dec.use_mem;
      s2_const_r   <= dec.const_byte;
      s2_status_r  <= dec.status;
    end
  end

  // Pick the stored level or the layout byte
  assign out_byte_nxt = s2_use_mem_r ? rd_data : s2_const_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r   <= out_byte_nxt;
      out_status_r <= s2_status_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_frame_byte = out_byte_r;
  assign out_status     = out_status_r;

  // No request may enter while the store is still being cleared
  `DMXUSB_ASSERT_IMP(a_no_accept_in_clear, accept, clr_done)
  // An error result always carries a zero byte
  `DMXUSB_ASSERT_IMP(a_err_zero_byte, out_vld_r && out_status_r == STS_RANGE, out_byte_r == BYTE_ZERO)
  // Pipeline is empty when the clearing pass ends
  `DMXUSB_ASSERT_IMP(a_empty_after_clear, $rose(clr_done), !s1_vld_r && !s2_vld_r && !out_vld_r)

endmodule

// File: sim/dmx_usb_packet_formatter_unit_tb.sv
// ----------------------------------------------------------------------------
// dmx_usb_packet_formatter_unit_tb
// Self-checking bench for the DMX channel store and USB frame formatter.
// A predictor keeps its own copy of the 512 channel levels and works out the
// expected frame byte and status for every accepted request. A checker pops
// the oldest expectation for every accepted result and compares each field.
// Both sides idle at random, and the receiver holds off once for a long
// stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmx_usb_packet_formatter_unit_tb;
  import dmxusb_pkg::*;

  localparam int unsigned GROUP_BYTES   = 6;
  localparam int unsigned IDX_PER_CHUNK = 10;
  localparam int unsigned MAX_IDLE      = 12;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  typedef struct {
    logic [7:0] frame_byte;
    logic       status;
  } frame_result_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic             in_cmd    = CMD_WRITE;
  logic [IDX_W-1:0] in_index  = '0;
  logic [7:0]       in_level  = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_frame_byte;
  logic             out_status;

  // Predictor state: the levels the block should hold right now.
  logic [7:0]    channel_levels [DMX_CHANNELS];
  frame_result_t pending_results [$];

  bit          sender_idle_en   = 1'b1;
  bit          receiver_idle_en = 1'b1;
  int unsigned hold_request     = 0;
  int unsigned error_count      = 0;
  int unsigned cycle_count      = 0;
  int unsigned write_count      = 0;
  int unsigned read_count       = 0;
  int unsigned range_count      = 0;
  int unsigned input_stall_count = 0;

  dmx_usb_packet_formatter_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_index       (in_index),
    .in_level       (in_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_status     (out_status)
  );

  always #2 clk = ~clk;

  // Bound the run; the clearing pass, idling and the hold-off all fit well inside.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Compute one byte of the USB frame from the predicted channel levels.
  function automatic logic [7:0] predict_frame_byte(int unsigned offset);
    int unsigned chunk;
    int unsigned pos;
    int unsigned grp;
    int unsigned slot;
    int unsigned chan;
    bit          last_chunk;
    chunk      = offset / CHUNK_BYTES;
    pos        = offset % CHUNK_BYTES;
    last_chunk = (chunk == CHUNKS_PER_FRAME - 1);
    if (pos == 0) return BYTE_MARK;
    if (pos == CHUNK_BYTES - 1) return BYTE_ZERO;
    grp  = (pos - 1) / GROUP_BYTES;
    slot = (pos - 1) % GROUP_BYTES;
    // The short last chunk carries only three groups; the rest is padding.
    if (last_chunk && grp >= 3) return BYTE_ZERO;
    if (slot == 0) return 8'(chunk * IDX_PER_CHUNK + 2 * grp);
    if (slot == 1) return (grp == 4 || (last_chunk && grp == 2)) ? BYTE_TAG_LAST : BYTE_TAG_MORE;
    chan = chunk * CHANS_PER_CHUNK + 4 * grp + (slot - 2);
    if (chan >= DMX_CHANNELS) return BYTE_ZERO;
    return channel_levels[chan];
  endfunction

  // Predict on every accepted request: update the store, queue the result.
  always @(posedge clk) begin : predict_on_accept
    frame_result_t exp_res;
    if (rst_n && in_valid && in_ready) begin
      exp_res.frame_byte = BYTE_ZERO;
      exp_res.status     = STS_OK;
      if (in_cmd == CMD_WRITE) begin
        write_count <= write_count + 1;
        if (in_index < DMX_CHANNELS) begin
          channel_levels[in_index] = in_level;
        end else begin
          exp_res.status = STS_RANGE;
        end
      end else begin
        read_count <= read_count + 1;
        if (in_index < FRAME_BYTES) begin
          exp_res.frame_byte = predict_frame_byte(in_index);
        end else begin
          exp_res.status = STS_RANGE;
        end
      end
      if (exp_res.status == STS_RANGE) range_count <= range_count + 1;
      pending_results.push_back(exp_res);
    end
    if (rst_n && in_valid && !in_ready && !out_ready) input_stall_count <= input_stall_count + 1;
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : check_on_accept
    frame_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result frame_byte=%02h status=%0b", $time,
                 out_frame_byte, out_status);
        error_count = error_count + 1;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_frame_byte !== exp_res.frame_byte) begin
          $display("%0t: frame_byte mismatch expected=%02h actual=%02h", $time,
                   exp_res.frame_byte, out_frame_byte);
          error_count = error_count + 1;
        end
        if (out_status !== exp_res.status) begin
          $display("%0t: status mismatch expected=%0b actual=%0b", $time,
                   exp_res.status, out_status);
          error_count = error_count + 1;
        end
      end
    end
  end

  // Receiver: draw a stall per result, or take a pending long hold-off.
  initial begin : drive_out_ready
    int unsigned stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = receiver_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      if (hold_request != 0) begin
        stall        = hold_request;
        hold_request = 0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Send one request: idle for a drawn gap, then hold it until accepted.
  // Valid stays high on return so a gap-free next request keeps it high.
  task automatic send_request(logic cmd, int unsigned idx, logic [7:0] lvl);
    int unsigned gap;
    gap = sender_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_index <= IDX_W'(idx);
    in_level <= lvl;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Mostly legal writes and reads, with a share of out-of-range requests.
  task automatic send_random_request();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      send_request(CMD_WRITE, $urandom_range(0, DMX_CHANNELS - 1), 8'($urandom));
    end else if (pick < 8) begin
      send_request(CMD_READ, $urandom_range(0, FRAME_BYTES - 1), 8'($urandom));
    end else if (pick == 8) begin
      send_request(CMD_WRITE, $urandom_range(DMX_CHANNELS, 1023), 8'($urandom));
    end else begin
      send_request(CMD_READ, $urandom_range(FRAME_BYTES, 1023), 8'($urandom));
    end
  endtask

  // Hit the field extremes, every byte kind and both range errors.
  task automatic test_directed_corners();
    send_request(CMD_WRITE, 0, 8'hFF);
    send_request(CMD_WRITE, DMX_CHANNELS - 1, 8'hA5);
    send_request(CMD_WRITE, 19, 8'h00);
    send_request(CMD_WRITE, DMX_CHANNELS, 8'h5A);   // first channel past the end
    send_request(CMD_WRITE, 1023, 8'hFF);
    send_request(CMD_READ, 0, 8'h00);               // chunk marker
    send_request(CMD_READ, 1, 8'hFF);               // half-channel index
    send_request(CMD_READ, 2, 8'h00);               // continuation tag
    send_request(CMD_READ, 3, 8'h00);               // level of channel 0
    send_request(CMD_READ, 25, 8'h00);              // index of the fifth group
    send_request(CMD_READ, 26, 8'h00);              // final tag of a full chunk
    send_request(CMD_READ, 30, 8'h00);              // level of channel 19
    send_request(CMD_READ, CHUNK_BYTES - 1, 8'h00); // trailing pad
    send_request(CMD_READ, 793, 8'h00);             // highest index of chunk 24
    send_request(CMD_READ, 800, 8'h00);             // marker of the short chunk
    send_request(CMD_READ, 813, 8'h00);
    send_request(CMD_READ, 814, 8'h00);             // final tag of the short chunk
    send_request(CMD_READ, 818, 8'h00);             // level of channel 511
    send_request(CMD_READ, 819, 8'h00);             // padding of the short chunk
    send_request(CMD_READ, FRAME_BYTES - 1, 8'h00);
    send_request(CMD_READ, FRAME_BYTES, 8'h00);     // first offset past the frame
    send_request(CMD_READ, 1023, 8'hFF);
  endtask

  task automatic test_random_traffic(int unsigned count);
    repeat (count) send_random_request();
  endtask

  // Drop idling on both sides to run at full rate.
  task automatic test_back_to_back(int unsigned count);
    sender_idle_en   = 1'b0;
    receiver_idle_en = 1'b0;
    repeat (count) send_random_request();
    sender_idle_en   = 1'b1;
    receiver_idle_en = 1'b1;
  endtask

  // Read the whole frame in order, as the USB endpoint would.
  task automatic test_full_frame_sweep();
    for (int unsigned off = 0; off < FRAME_BYTES; off++) begin
      send_request(CMD_READ, off, 8'($urandom));
    end
  endtask

  // Hold off the receiver while the sender keeps offering requests.
  task automatic test_output_backpressure();
    sender_idle_en = 1'b0;
    hold_request   = HOLD_CYCLES;
    repeat (64) send_random_request();
    sender_idle_en = 1'b1;
  endtask

  initial begin : run_tests
    foreach (channel_levels[i]) channel_levels[i] = 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_random_traffic(300);
    test_full_frame_sweep();
    test_output_backpressure();
    test_back_to_back(200);
    test_random_traffic(250);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d channel writes and %0d frame reads, %0d of them out of range.",
             write_count, read_count, range_count);
    $display("Input stalled for %0d cycles under receiver hold-off.", input_stall_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: dmx_usb_packet_formatter_unit.f
+incdir+design
design/dmxusb_pkg.sv
design/dmxusb_decode.sv
design/dmxusb_store.sv
design/dmx_usb_packet_formatter_unit.sv
sim/dmx_usb_packet_formatter_unit_tb.sv
